// ----- rtl/tvsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tvsd_pkg
// Shared types and constants for the vector stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package tvsd_pkg;
    localparam int unsigned QueueDepth = 2;

    localparam logic [2:0] MODE_ALPHA = 3'd0;
    localparam logic [2:0] MODE_MOVE  = 3'd1;
    localparam logic [2:0] MODE_LINE  = 3'd2;
    localparam logic [2:0] MODE_POINT = 3'd3;
    localparam logic [2:0] MODE_GIN   = 3'd4;
    localparam logic [2:0] MODE_INCR  = 3'd5;

    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_M    = 2'd1;
    localparam logic [1:0] PFX_PEN  = 2'd2;

    localparam logic [3:0] CMD_NONE  = 4'd0;
    localparam logic [3:0] CMD_MOVE  = 4'd1;
    localparam logic [3:0] CMD_LINE  = 4'd2;
    localparam logic [3:0] CMD_RECT  = 4'd3;
    localparam logic [3:0] CMD_POINT = 4'd4;
    localparam logic [3:0] CMD_CHAR  = 4'd5;
    localparam logic [3:0] CMD_COLOR = 4'd6;
    localparam logic [3:0] CMD_PEN   = 4'd7;
    localparam logic [3:0] CMD_CLEAR = 4'd8;
    localparam logic [3:0] CMD_RESET = 4'd9;
    localparam logic [3:0] CMD_BEEP  = 4'd10;
    localparam logic [3:0] CMD_OFF   = 4'd11;

    localparam logic [0:0] REG_SCALE  = 1'd0;
    localparam logic [0:0] REG_INTERL = 1'd1;

    localparam logic [9:0] XMAX  = 10'd640;
    localparam logic [8:0] YMAX  = 9'd256;
    localparam logic [8:0] STEPY = 9'd10;

    typedef struct packed {
        logic [3:0] command;
        logic [9:0] pos_x;
        logic [8:0] pos_y;
        logic [9:0] from_x;
        logic [8:0] from_y;
        logic [7:0] char_code;
        logic [7:0] colour_index;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [7:0] pen_value;
        logic       consumed;
    } t_result;
endpackage
`default_nettype wire

// ----- rtl/tek4010_vector_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// tek4010_vector_stream_decoder
// Decodes a terminal byte stream into drawing commands.
// Path from byte accept to result: the queue, then the decode register.
// Throughput: 1 byte per cycle while i_ready does not stall the output.
// Reset: synchronous active-low; scale and interlace enabled, move mode.
// ----------------------------------------------------------------------------
`default_nettype none
module tek4010_vector_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = tvsd_pkg::QueueDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [0:0] i_cfg_idx,
    input  wire logic [0:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [3:0]      o_command,
    output logic [9:0]      o_pos_x,
    output logic [8:0]      o_pos_y,
    output logic [9:0]      o_from_x,
    output logic [8:0]      o_from_y,
    output logic [7:0]      o_char_code,
    output logic [7:0]      o_colour_index,
    output logic [7:0]      o_red_level,
    output logic [7:0]      o_green_level,
    output logic [7:0]      o_blue_level,
    output logic [7:0]      o_pen_value,
    output logic            o_consumed
);
    logic r_scale, r_interl;
    logic w_qv, w_qr;
    logic [7:0] w_qd;
    tvsd_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 1'b1;
            r_interl <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tvsd_pkg::REG_SCALE) r_scale <= i_cfg_data[0];
            if (i_cfg_idx == tvsd_pkg::REG_INTERL) r_interl <= i_cfg_data[0];
        end
    end

    tvsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_rx_byte),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qd)
    );

    tvsd_core u_core (
        .i_clk, .i_rst_n,
        .i_scale(r_scale), .i_interl(r_interl),
        .i_valid(w_qv), .o_ready(w_qr), .i_byte(w_qd),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(w_res)
    );

    assign o_command      = w_res.command;
    assign o_pos_x        = w_res.pos_x;
    assign o_pos_y        = w_res.pos_y;
    assign o_from_x       = w_res.from_x;
    assign o_from_y       = w_res.from_y;
    assign o_char_code    = w_res.char_code;
    assign o_colour_index = w_res.colour_index;
    assign o_red_level    = w_res.red_level;
    assign o_green_level  = w_res.green_level;
    assign o_blue_level   = w_res.blue_level;
    assign o_pen_value    = w_res.pen_value;
    assign o_consumed     = w_res.consumed;
endmodule
`default_nettype wire

// ----- rtl/tvsd_queue.sv -----
// ----------------------------------------------------------------------------
// tvsd_queue
// Small FIFO of received bytes between the front and the decode core.
// ----------------------------------------------------------------------------
`default_nettype none
module tvsd_queue #(
    parameter int unsigned DEPTH = tvsd_pkg::QueueDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wp  = w_push ? ((r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp  = w_pop ? ((r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt + CW'(w_push) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/tvsd_core.sv -----
// ----------------------------------------------------------------------------
// tvsd_core
// Decode state machine: one byte per cycle, while i_ready does not stall the output, into one registered result.
// ----------------------------------------------------------------------------
`default_nettype none
module tvsd_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_scale,
    input  wire logic       i_interl,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output tvsd_pkg::t_result o_res
);
    logic [2:0] r_mode, n_mode;
    logic       r_esc, n_esc;
    logic [2:0] r_cstep, n_cstep;
    logic [7:0] r_hci, n_hci, r_hr, n_hr, r_hg, n_hg;
    logic [1:0] r_pfx, n_pfx;
    logic [9:0] r_hx, n_hx, r_hy, n_hy;
    logic [4:0] r_ly, n_ly;
    logic [1:0] r_ptag, n_ptag;
    logic [9:0] r_cx, n_cx;
    logic [8:0] r_cy, n_cy;
    logic       r_box, n_box;
    logic [7:0] r_pen, n_pen;
    logic       r_gact, n_gact;
    logic       r_ov;
    tvsd_pkg::t_result r_res, n_res;

    logic       w_take;
    logic [7:0] w_v;
    logic [1:0] w_tag;
    logic [9:0] w_x0, w_y0, w_xs, w_ys, w_xh, w_yh;
    logic [19:0] w_xm;
    logic [18:0] w_ym;
    logic [9:0] w_cxa;
    logic [8:0] w_cya;

    assign o_ready = !r_ov || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_comb begin
        w_v   = i_byte - 8'h30;
        w_tag = i_byte[6:5];
        w_x0  = r_hx + {5'd0, i_byte[4:0]};
        w_y0  = r_hy + {5'd0, r_ly};
        w_xm  = {w_x0, 9'd0} + {2'd0, w_x0, 7'd0} + 20'd512;
        w_ym  = {1'b0, w_y0, 8'd0} + 19'd512;
        w_xs  = i_scale ? w_xm[19:10] : w_x0;
        w_ys  = i_scale ? {1'b0, w_ym[18:10]} : w_y0;
        w_xh  = i_interl ? w_xs : {1'b0, w_xs[9:1]};
        w_yh  = i_interl ? w_ys : {1'b0, w_ys[9:1]};
        w_cxa = (r_cx > 10'd632) ? 10'd632 : r_cx;
        w_cya = (r_cy < tvsd_pkg::STEPY) ? tvsd_pkg::STEPY :
                (r_cy > tvsd_pkg::YMAX) ? tvsd_pkg::YMAX : r_cy;

        n_mode = r_mode; n_esc = r_esc; n_cstep = r_cstep;
        n_hci = r_hci; n_hr = r_hr; n_hg = r_hg; n_pfx = r_pfx;
        n_hx = r_hx; n_hy = r_hy; n_ly = r_ly; n_ptag = r_ptag;
        n_cx = r_cx; n_cy = r_cy; n_box = r_box; n_pen = r_pen; n_gact = r_gact;
        n_res = '0;
        n_res.command  = tvsd_pkg::CMD_NONE;
        n_res.from_x   = r_cx;
        n_res.from_y   = r_cy;
        n_res.consumed = 1'b1;
        n_res.pos_x    = 10'd0;

        if (r_esc) begin
            if (r_cstep != 3'd0) begin
                n_cstep = r_cstep + 3'd1;
                case (r_cstep)
                    3'd1: n_hci = w_v;
                    3'd2: n_hr = w_v;
                    3'd3: n_hg = w_v;
                    default: begin
                        n_res.command      = tvsd_pkg::CMD_COLOR;
                        n_res.colour_index = r_hci;
                        n_res.red_level    = r_hr;
                        n_res.green_level  = r_hg;
                        n_res.blue_level   = w_v;
                        n_cstep = 3'd0;
                        n_esc   = 1'b0;
                    end
                endcase
                n_res.consumed = r_gact;
            end else if (i_byte == 8'h51) begin
                n_cstep = 3'd1;
                n_res.consumed = r_gact;
            end else begin
                case (i_byte)
                    8'h32: begin
                        n_gact = 1'b0; n_box = 1'b0;
                        n_res.command = tvsd_pkg::CMD_OFF;
                    end
                    8'h41: n_box = 1'b1;
                    8'h42: n_box = 1'b0;
                    8'h52, 8'h0C: begin
                        if (i_byte == 8'h52) begin
                            n_pen = 8'd1;
                            n_res.command = tvsd_pkg::CMD_RESET;
                        end else begin
                            n_res.command = tvsd_pkg::CMD_CLEAR;
                        end
                        n_cx = 10'd0; n_cy = tvsd_pkg::STEPY;
                        n_mode = tvsd_pkg::MODE_ALPHA;
                        n_pfx = tvsd_pkg::PFX_NONE;
                    end
                    8'h4D: n_pfx = tvsd_pkg::PFX_M;
                    default: ;
                endcase
                n_esc = 1'b0;
            end
        end else if (r_pfx != tvsd_pkg::PFX_NONE) begin
            if (r_pfx == tvsd_pkg::PFX_PEN) n_pen = w_v;
            n_res.command = tvsd_pkg::CMD_PEN;
            n_pfx = (r_pfx == tvsd_pkg::PFX_M && i_byte == 8'h4C) ?
                    tvsd_pkg::PFX_PEN : tvsd_pkg::PFX_NONE;
        end else if (i_byte >= 8'h20 && i_byte <= 8'h7E) begin
            if (r_mode == tvsd_pkg::MODE_ALPHA) begin
                n_res.command   = tvsd_pkg::CMD_CHAR;
                n_res.char_code = i_byte;
                n_cx = w_cxa + 10'd8;
                n_cy = w_cya;
            end else begin
                case (w_tag)
                    2'd1: begin
                        if (r_ptag == 2'd3) n_hx = {i_byte[4:0], 5'd0};
                        else n_hy = {i_byte[4:0], 5'd0};
                    end
                    2'd2: begin
                        n_cx = (w_xh > tvsd_pkg::XMAX) ? tvsd_pkg::XMAX : w_xh;
                        n_cy = (w_yh > 10'd256) ? tvsd_pkg::YMAX : w_yh[8:0];
                        case (r_mode)
                            tvsd_pkg::MODE_MOVE: begin
                                n_mode = tvsd_pkg::MODE_LINE;
                                n_res.command = tvsd_pkg::CMD_MOVE;
                            end
                            tvsd_pkg::MODE_LINE: n_res.command =
                                r_box ? tvsd_pkg::CMD_RECT : tvsd_pkg::CMD_LINE;
                            tvsd_pkg::MODE_POINT: n_res.command = tvsd_pkg::CMD_POINT;
                            default: ;
                        endcase
                    end
                    2'd3: n_ly = i_byte[4:0];
                    default: ;
                endcase
                n_ptag = w_tag;
            end
        end else begin
            case (i_byte)
                8'h07: n_res.command = tvsd_pkg::CMD_BEEP;
                8'h08: n_cx = (r_cx < 10'd8) ? 10'd0 : r_cx - 10'd8;
                8'h09: n_cx = (r_cx > 10'd632) ? tvsd_pkg::XMAX : r_cx + 10'd8;
                8'h0A: n_cy = (r_cy > 9'd246) ? tvsd_pkg::YMAX : r_cy + 9'd10;
                8'h0B: n_cy = (r_cy < 9'd20) ? tvsd_pkg::STEPY : r_cy - 9'd10;
                8'h0D: begin n_cx = 10'd0; n_mode = tvsd_pkg::MODE_ALPHA; end
                8'h18: begin
                    n_gact = 1'b0; n_box = 1'b0;
                    n_res.command = tvsd_pkg::CMD_OFF;
                end
                8'h1A: n_mode = tvsd_pkg::MODE_GIN;
                8'h1B: n_esc = 1'b1;
                8'h1C: n_mode = tvsd_pkg::MODE_POINT;
                8'h1D: n_mode = tvsd_pkg::MODE_MOVE;
                8'h1E: n_mode = tvsd_pkg::MODE_INCR;
                8'h1F: n_mode = tvsd_pkg::MODE_ALPHA;
                default: ;
            endcase
        end

        if (n_res.command == tvsd_pkg::CMD_CHAR) begin
            n_res.pos_x     = w_cxa;
            n_res.pos_y     = w_cya;
            n_res.pen_value = 8'd1;
        end else begin
            n_res.pos_x     = n_cx;
            n_res.pos_y     = n_cy;
            n_res.pen_value = n_pen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tvsd_pkg::MODE_MOVE; r_esc <= 1'b0; r_cstep <= 3'd0;
            r_hci <= '0; r_hr <= '0; r_hg <= '0; r_pfx <= tvsd_pkg::PFX_NONE;
            r_hx <= '0; r_hy <= '0; r_ly <= '0; r_ptag <= '0;
            r_cx <= '0; r_cy <= tvsd_pkg::STEPY; r_box <= 1'b0;
            r_pen <= 8'd1; r_gact <= 1'b1; r_ov <= 1'b0;
        end else begin
            if (w_take) begin
                r_mode <= n_mode; r_esc <= n_esc; r_cstep <= n_cstep;
                r_hci <= n_hci; r_hr <= n_hr; r_hg <= n_hg; r_pfx <= n_pfx;
                r_hx <= n_hx; r_hy <= n_hy; r_ly <= n_ly; r_ptag <= n_ptag;
                r_cx <= n_cx; r_cy <= n_cy; r_box <= n_box;
                r_pen <= n_pen; r_gact <= n_gact;
            end
            if (o_ready) r_ov <= i_valid;
        end
        if (w_take) r_res <= n_res;
    end
endmodule
`default_nettype wire
